@@ hdl/ps2mq_pkg.sv @@
// Shared types and constants for the PS/2 mouse cursor event queue.
// Used by the top level and by its port checker; depends on nothing.
package ps2mq_pkg;

  // Input command codes carried on s_tuser.
  localparam logic [1:0] CMD_PS2_BYTE = 2'd0;
  localparam logic [1:0] CMD_USB_RPT  = 2'd1;
  localparam logic [1:0] CMD_POP      = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_USB_MODE      = 2'd2;

  // Bit positions inside the first byte of a PS/2 packet.
  localparam int BIT_SYNC  = 3;
  localparam int BIT_X_OVF = 6;
  localparam int BIT_Y_OVF = 7;

  // Reset values and screen limits.
  localparam logic [12:0] WIDTH_RST      = 13'd1024;
  localparam logic [12:0] HEIGHT_RST     = 13'd768;
  localparam logic [12:0] SIZE_MAX       = 13'd4096;
  localparam logic [11:0] CURSOR_X_RST   = 12'd512;
  localparam logic [11:0] CURSOR_Y_RST   = 12'd384;
  localparam logic [11:0] LIMIT_X_ZERO   = 12'd1023;
  localparam logic [11:0] LIMIT_Y_ZERO   = 12'd767;
  localparam logic [11:0] LIMIT_MAX      = 12'd4095;

  // One queued event, as stored in the queue memory.
  typedef struct packed {
    logic [31:0] seq;
    logic [2:0]  changed;
    logic [2:0]  buttons;
    logic [7:0]  dy;
    logic [7:0]  dx;
    logic [11:0] y;
    logic [11:0] x;
  } entry_t;

endpackage

@@ hdl/ps2_mouse_cursor_event_queue.sv @@
// PS/2 mouse cursor event queue: packet assembly, cursor tracking and event ring.
// Depends on ps2mq_pkg for command codes, register indexes and the entry type.
//
// Usage
//   The slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one command per
//   beat: s_tuser selects a PS/2 data byte, a USB report or a pop of the event
//   queue. PS/2 bytes are gathered into three-byte packets; each packet or USB
//   report moves the cursor, clamped to the configured screen, and queues an
//   event when the position or the buttons change. Only a pop produces a result.
//   Every pop yields exactly one beat on the master stream; m_tuser is high when
//   an event was taken and low when the queue was empty, in which case all event
//   fields are zero and only the overrun total is meaningful.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready and sets the screen size and USB mode; write it only while idle.
// Timing
//   One beat can be accepted per cycle while s_tready is high; s_tready drops when
//   the read stage is full and cannot advance. A pop result reaches the master side
//   through the registered read of the queue memory and then the output register.
// Reset and stall
//   Reset clears the cursor to the middle of the default screen, empties the queue
//   and the counters; no memory clearing pass is run. When the receiver stalls, one
//   result waits in the output register and a second in the read stage; the slave
//   side then stops accepting until the output register drains.
module ps2_mouse_cursor_event_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  // Slave stream. tdata from bit 0: data_byte[7:0], usb_dx[7:0], usb_dy[7:0],
  // usb_buttons[7:0].
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,
  // tuser: cmd[1:0].
  input  logic [1:0]   s_tuser,
  // Master stream. tdata from bit 0: event_x[11:0], event_y[11:0], event_dx[7:0],
  // event_dy[7:0], event_buttons[2:0], event_changed[2:0], event_seq[31:0],
  // dropped_events[31:0], two zero pad bits.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,
  // tuser: event_valid.
  output logic         m_tuser,
  // Configuration write channel.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers.
  logic [12:0] screen_width;
  logic [12:0] screen_height;
  logic        usb_mode;

  // Packet and cursor state.
  logic [1:0]  pkt_count;
  logic [7:0]  pkt_byte0;
  logic [7:0]  pkt_byte1;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic [2:0]  held_buttons;
  logic [31:0] event_seq;
  logic [31:0] overrun_total;
  logic [PTR_W-1:0] wr_slot;
  logic [PTR_W-1:0] rd_slot;

  // Event ring and its registered read port.
  ps2mq_pkg::entry_t queue_mem [QUEUE_DEPTH];
  ps2mq_pkg::entry_t rd_entry;

  // Read stage and output register.
  logic              p1_valid;
  logic              p1_hit;
  logic [31:0]       p1_dropped;
  logic              out_valid;
  logic              out_hit;
  ps2mq_pkg::entry_t out_entry;
  logic [31:0]       out_dropped;

  logic p1_adv;
  logic in_acc;
  logic is_ps2;
  logic is_usb;
  logic is_pop;

  logic [7:0] in_byte;
  logic [7:0] usb_dx;
  logic [7:0] usb_dy;
  logic [7:0] usb_buttons;

  logic       motion;
  logic [7:0] mv_dx;
  logic [7:0] mv_dy;
  logic [2:0] mv_buttons;

  logic [11:0] limit_x;
  logic [11:0] limit_y;
  logic [13:0] sum_x;
  logic [13:0] sum_y;
  logic [11:0] new_x;
  logic [11:0] new_y;
  logic [2:0]  changed;
  logic        push;
  logic [PTR_W-1:0] wr_slot_next;
  logic        ring_full;
  logic        queue_empty;
  ps2mq_pkg::entry_t push_entry;

  assign in_byte     = s_tdata[7:0];
  assign usb_dx      = s_tdata[15:8];
  assign usb_dy      = s_tdata[23:16];
  assign usb_buttons = s_tdata[31:24];

  assign p1_adv   = p1_valid && (!out_valid || m_tready);
  assign s_tready = !p1_valid || p1_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign is_ps2   = in_acc && (s_tuser == ps2mq_pkg::CMD_PS2_BYTE) && !usb_mode;
  assign is_usb   = in_acc && (s_tuser == ps2mq_pkg::CMD_USB_RPT);
  assign is_pop   = in_acc && (s_tuser == ps2mq_pkg::CMD_POP);
  assign cfg_ready = 1'b1;

  // Motion source: the third byte of a PS/2 packet or a USB report. An overflow
  // flag in the first packet byte zeroes the matching delta.
  always_comb begin
    motion     = 1'b0;
    mv_dx      = usb_dx;
    mv_dy      = usb_dy;
    mv_buttons = usb_buttons[2:0];
    if (is_usb) begin
      motion = 1'b1;
    end else if (is_ps2 && (pkt_count >= 2'd2)) begin
      motion     = 1'b1;
      mv_dx      = pkt_byte0[ps2mq_pkg::BIT_X_OVF] ? 8'd0 : pkt_byte1;
      mv_dy      = pkt_byte0[ps2mq_pkg::BIT_Y_OVF] ? 8'd0 : in_byte;
      mv_buttons = pkt_byte0[2:0];
    end
  end

  // Screen limits: zero size falls back to the default screen, oversize caps at 4095.
  always_comb begin
    if (screen_width == 13'd0) begin
      limit_x = ps2mq_pkg::LIMIT_X_ZERO;
    end else if (screen_width > ps2mq_pkg::SIZE_MAX) begin
      limit_x = ps2mq_pkg::LIMIT_MAX;
    end else begin
      limit_x = 12'(screen_width - 13'd1);
    end
    if (screen_height == 13'd0) begin
      limit_y = ps2mq_pkg::LIMIT_Y_ZERO;
    end else if (screen_height > ps2mq_pkg::SIZE_MAX) begin
      limit_y = ps2mq_pkg::LIMIT_MAX;
    end else begin
      limit_y = 12'(screen_height - 13'd1);
    end
  end

  // Cursor update; Y moves opposite to the reported delta.
  always_comb begin
    sum_x = {2'b00, cursor_x} + {{6{mv_dx[7]}}, mv_dx};
    sum_y = {2'b00, cursor_y} - {{6{mv_dy[7]}}, mv_dy};
    if (sum_x[13]) begin
      new_x = 12'd0;
    end else if (sum_x > {2'b00, limit_x}) begin
      new_x = limit_x;
    end else begin
      new_x = sum_x[11:0];
    end
    if (sum_y[13]) begin
      new_y = 12'd0;
    end else if (sum_y > {2'b00, limit_y}) begin
      new_y = limit_y;
    end else begin
      new_y = sum_y[11:0];
    end
    changed = mv_buttons ^ held_buttons;
    push    = motion && ((new_x != cursor_x) || (new_y != cursor_y) || (changed != 3'd0));
  end

  assign wr_slot_next = ptr_inc(wr_slot);
  assign ring_full    = (wr_slot_next == rd_slot);
  assign queue_empty  = (rd_slot == wr_slot);

  always_comb begin
    push_entry.x       = new_x;
    push_entry.y       = new_y;
    push_entry.dx      = mv_dx;
    push_entry.dy      = mv_dy;
    push_entry.buttons = mv_buttons;
    push_entry.changed = changed;
    push_entry.seq     = event_seq + 32'd1;
  end

  // Queue memory: one write port for pushes, one registered read port for pops.
  // A push and a pop never share a cycle; a pop on an empty queue reads the write slot, whose data is zeroed on output.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_slot] <= push_entry;
    end
    if (is_pop) begin
      rd_entry <= queue_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= ps2mq_pkg::WIDTH_RST;
      screen_height <= ps2mq_pkg::HEIGHT_RST;
      usb_mode      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ps2mq_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        ps2mq_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        ps2mq_pkg::REG_USB_MODE:      usb_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Packet assembly. While no byte is held, a byte without the sync bit is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_count <= 2'd0;
      pkt_byte0 <= 8'd0;
      pkt_byte1 <= 8'd0;
    end else if (is_ps2) begin
      case (pkt_count)
        2'd0: begin
          if (in_byte[ps2mq_pkg::BIT_SYNC]) begin
            pkt_byte0 <= in_byte;
            pkt_count <= 2'd1;
          end
        end
        2'd1: begin
          pkt_byte1 <= in_byte;
          pkt_count <= 2'd2;
        end
        default: begin
          pkt_count <= 2'd0;
        end
      endcase
    end
  end

  // Cursor, counters and ring pointers. A push into a full ring drops the oldest.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x      <= ps2mq_pkg::CURSOR_X_RST;
      cursor_y      <= ps2mq_pkg::CURSOR_Y_RST;
      held_buttons  <= 3'd0;
      event_seq     <= 32'd0;
      overrun_total <= 32'd0;
      wr_slot       <= '0;
      rd_slot       <= '0;
    end else if (push) begin
      cursor_x     <= new_x;
      cursor_y     <= new_y;
      held_buttons <= mv_buttons;
      event_seq    <= event_seq + 32'd1;
      wr_slot      <= wr_slot_next;
      if (ring_full) begin
        overrun_total <= overrun_total + 32'd1;
        rd_slot       <= ptr_inc(rd_slot);
      end
    end else if (is_pop && !queue_empty) begin
      rd_slot <= ptr_inc(rd_slot);
    end
  end

  // Read stage: remembers whether the pop found an event and the overrun total.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (is_pop) begin
      p1_valid <= 1'b1;
    end else if (p1_adv) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_pop) begin
      p1_hit     <= !queue_empty;
      p1_dropped <= overrun_total;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      out_hit     <= p1_hit;
      out_entry   <= rd_entry;
      out_dropped <= p1_dropped;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_hit;
  assign m_tdata  = {2'b00, out_dropped, out_hit ? out_entry : '0};

endmodule

@@ hdl/ps2mq_checker.sv @@
// Port-level checker for the PS/2 mouse cursor event queue, bound to the top level.
// Depends on ps2mq_pkg for the pop command code.
module ps2mq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tuser
);

  // Nothing is shown on the master side in the cycle after reset.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // An empty pop carries zero event fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[77:0] == 78'd0))
    else $error("empty pop carries event data");

  // A new result on an idle output comes from a pop through the read stage.
  a_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && !$past(rst, 1) && !$past(rst, 2) |->
      $past(s_tvalid && s_tready && (s_tuser == ps2mq_pkg::CMD_POP), 2))
    else $error("result without a matching pop");

endmodule

bind ps2_mouse_cursor_event_queue ps2mq_checker u_ps2mq_checker (.*);
